### rtl/chhic_pkg.sv
`timescale 1ns / 1ps

package chhic_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int AXIS_W = 16;
    localparam int HEAD_W = 9;
    localparam int BUSY_BIT = 5;

    // centered axis difference
    localparam int DIFF_W = AXIS_W + 2;

    // cordic datapath
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int SCALE_W = 24;
    localparam int VEC_W = 48;
    localparam int DIGIT_W = 4;
    localparam int NDIG = VEC_W / DIGIT_W;
    localparam int DIG_CW = $clog2(NDIG);
    localparam int POS_W = $clog2(VEC_W);
    localparam int ABS_W = $clog2(2 * VEC_W);
    localparam int TIDX_W = 5;
    localparam int ATAN_W = 22;
    localparam int FRAC_W = 16;
    localparam int ANG_W = 26;

    // degree arithmetic
    localparam int DEG_W = 11;
    localparam logic signed [DEG_W-1:0] DEG_360 = DEG_W'(360);
    localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);

    // extreme tracker reset values
    localparam logic signed [AXIS_W-1:0] LOWEST_RST = AXIS_W'(32767);
    localparam logic signed [AXIS_W-1:0] HIGHEST_RST = AXIS_W'(-32767);

    typedef struct packed {
        logic upd;
        logic ctr;
    } t_cal_ctl;

    // atan(2^-i) in degrees, 16 fraction bits, rounded
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [TIDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0: v = ATAN_W'(2949120);
            5'd1: v = ATAN_W'(1740967);
            5'd2: v = ATAN_W'(919879);
            5'd3: v = ATAN_W'(466945);
            5'd4: v = ATAN_W'(234379);
            5'd5: v = ATAN_W'(117304);
            5'd6: v = ATAN_W'(58666);
            5'd7: v = ATAN_W'(29335);
            5'd8: v = ATAN_W'(14668);
            5'd9: v = ATAN_W'(7334);
            5'd10: v = ATAN_W'(3667);
            5'd11: v = ATAN_W'(1833);
            5'd12: v = ATAN_W'(917);
            5'd13: v = ATAN_W'(458);
            5'd14: v = ATAN_W'(229);
            5'd15: v = ATAN_W'(115);
            5'd16: v = ATAN_W'(57);
            5'd17: v = ATAN_W'(29);
            5'd18: v = ATAN_W'(14);
            5'd19: v = ATAN_W'(7);
            5'd20: v = ATAN_W'(4);
            5'd21: v = ATAN_W'(2);
            5'd22: v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/chhic_in_if.sv
`timescale 1ns / 1ps

interface chhic_in_if import chhic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] y_high_byte;
    logic [BYTE_W-1:0] y_low_byte;
    logic [BYTE_W-1:0] x_high_byte;
    logic [BYTE_W-1:0] x_low_byte;
    logic [BYTE_W-1:0] z_high_byte;
    logic [BYTE_W-1:0] z_low_byte;

    modport source (
        output valid, status_byte, y_high_byte, y_low_byte,
               x_high_byte, x_low_byte, z_high_byte, z_low_byte,
        input  ready
    );
    modport sink (
        input  valid, status_byte, y_high_byte, y_low_byte,
               x_high_byte, x_low_byte, z_high_byte, z_low_byte,
        output ready
    );
endinterface

### rtl/chhic_out_if.sv
`timescale 1ns / 1ps

interface chhic_out_if import chhic_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic [HEAD_W-1:0]        heading_degrees;
    logic signed [AXIS_W-1:0] x_value;
    logic signed [AXIS_W-1:0] y_value;
    logic signed [AXIS_W-1:0] z_value;

    modport source (
        output valid, accepted, heading_degrees, x_value, y_value, z_value,
        input  ready
    );
    modport sink (
        input  valid, accepted, heading_degrees, x_value, y_value, z_value,
        output ready
    );
endinterface

### rtl/chhic_cfg_if.sv
`timescale 1ns / 1ps

interface chhic_cfg_if import chhic_pkg::*; ();
    logic valid;
    logic ready;
    logic calibrate_enable;

    modport source (
        output valid, calibrate_enable,
        input  ready
    );
    modport sink (
        input  valid, calibrate_enable,
        output ready
    );
endinterface

### rtl/chhic_cal.sv
`timescale 1ns / 1ps

module chhic_cal import chhic_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr,
    input  logic                     i_cfg_en,
    input  t_cal_ctl                 i_ctl,
    input  logic signed [AXIS_W-1:0] i_x,
    input  logic signed [AXIS_W-1:0] i_y,
    output logic signed [DIFF_W-1:0] o_dx,
    output logic signed [DIFF_W-1:0] o_dy
);

    logic                     r_cal_en;
    logic signed [AXIS_W-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic signed [DIFF_W-1:0] r_dx, r_dy;

    logic signed [AXIS_W:0]   w_xsum, w_ysum, w_xadj, w_yadj;
    logic signed [AXIS_W-1:0] w_xmid, w_ymid;

    // midpoint, halved toward zero
    assign w_xsum = {r_x_low[AXIS_W-1], r_x_low} + {r_x_high[AXIS_W-1], r_x_high};
    assign w_ysum = {r_y_low[AXIS_W-1], r_y_low} + {r_y_high[AXIS_W-1], r_y_high};
    assign w_xadj = w_xsum + {{AXIS_W{1'b0}}, w_xsum[AXIS_W]};
    assign w_yadj = w_ysum + {{AXIS_W{1'b0}}, w_ysum[AXIS_W]};
    assign w_xmid = w_xadj[AXIS_W:1];
    assign w_ymid = w_yadj[AXIS_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_en <= 1'b0;
            r_x_low  <= LOWEST_RST;
            r_x_high <= HIGHEST_RST;
            r_y_low  <= LOWEST_RST;
            r_y_high <= HIGHEST_RST;
        end else if (i_cfg_wr) begin
            r_cal_en <= i_cfg_en;
            if (i_cfg_en) begin
                r_x_low  <= LOWEST_RST;
                r_x_high <= HIGHEST_RST;
                r_y_low  <= LOWEST_RST;
                r_y_high <= HIGHEST_RST;
            end
        end else if (i_ctl.upd && r_cal_en) begin
            if (i_x > r_x_high) r_x_high <= i_x;
            if (i_x < r_x_low)  r_x_low  <= i_x;
            if (i_y > r_y_high) r_y_high <= i_y;
            if (i_y < r_y_low)  r_y_low  <= i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ctr) begin
            r_dx <= {{2{i_x[AXIS_W-1]}}, i_x} - {{2{w_xmid[AXIS_W-1]}}, w_xmid};
            r_dy <= {{2{i_y[AXIS_W-1]}}, i_y} - {{2{w_ymid[AXIS_W-1]}}, w_ymid};
        end
    end

    assign o_dx = r_dx;
    assign o_dy = r_dy;

endmodule

### rtl/chhic_cordic.sv
`timescale 1ns / 1ps

module chhic_cordic import chhic_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIFF_W-1:0] i_ord,
    input  logic signed [DIFF_W-1:0] i_absc,
    output logic                     o_done,
    output logic signed [ANG_W-1:0]  o_angle
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic                    r_run, r_done;
    logic [VEC_W-1:0]        r_vx, r_vy;
    logic signed [ANG_W-1:0] r_z;
    logic [STEP_W-1:0]       r_step;
    logic [DIG_CW-1:0]       r_dig;
    logic                    r_cx, r_cy, r_xsgn, r_ysgn, r_ynz;

    logic [POS_W-1:0]   w_pos [DIGIT_W];
    logic [DIGIT_W-1:0] w_far, w_sx, w_sy, w_bx, w_by, w_nx, w_ny;
    logic               w_cx, w_cy, w_cin_x, w_cin_y;
    logic               w_last_dig, w_last_step, w_yzero, w_special, w_neg;
    logic [DIFF_W:0]    w_ax, w_ay;
    logic [ANG_W-1:0]   w_atan;

    // shifted taps: old bit (digit*4 + i + t) sits at index i + t, sign beyond the top
    always_comb begin
        for (int t = 0; t < DIGIT_W; t++) begin
            w_pos[t] = POS_W'(r_step) + POS_W'(t);
            w_far[t] = (ABS_W'(r_dig) * ABS_W'(DIGIT_W) + ABS_W'(w_pos[t]))
                       >= ABS_W'(VEC_W);
            w_sx[t]  = w_far[t] ? r_xsgn : r_vx[w_pos[t]];
            w_sy[t]  = w_far[t] ? r_ysgn : r_vy[w_pos[t]];
        end
    end

    // y >= 0 rotates clockwise: x += y>>i, y -= x>>i
    assign w_bx    = r_ysgn ? ~w_sy : w_sy;
    assign w_by    = r_ysgn ? w_sx : ~w_sx;
    assign w_cin_x = (r_dig == '0) ? r_ysgn : r_cx;
    assign w_cin_y = (r_dig == '0) ? !r_ysgn : r_cy;
    assign {w_cx, w_nx} = {1'b0, r_vx[DIGIT_W-1:0]} + {1'b0, w_bx}
                          + {{DIGIT_W{1'b0}}, w_cin_x};
    assign {w_cy, w_ny} = {1'b0, r_vy[DIGIT_W-1:0]} + {1'b0, w_by}
                          + {{DIGIT_W{1'b0}}, w_cin_y};

    assign w_last_dig  = r_dig == DIG_CW'(NDIG - 1);
    assign w_last_step = r_step == STEP_W'(CORDIC_STEPS - 1);
    assign w_yzero     = !(r_ynz | (|w_ny));
    assign w_atan      = {{(ANG_W-ATAN_W){1'b0}}, atan_deg(TIDX_W'(r_step))};

    // start: turn left-half vectors by 180 degrees
    assign w_special = (i_ord == '0) || (i_absc == '0);
    assign w_neg     = i_absc[DIFF_W-1];
    assign w_ax      = w_neg ? -{i_absc[DIFF_W-1], i_absc} : {i_absc[DIFF_W-1], i_absc};
    assign w_ay      = w_neg ? -{i_ord[DIFF_W-1], i_ord} : {i_ord[DIFF_W-1], i_ord};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= !w_special;
                r_done <= w_special;
            end else if (r_run && w_last_dig && (w_yzero || w_last_step)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_vx   <= {{(VEC_W-SCALE_W-DIFF_W-1){w_ax[DIFF_W]}}, w_ax, {SCALE_W{1'b0}}};
            r_vy   <= {{(VEC_W-SCALE_W-DIFF_W-1){w_ay[DIFF_W]}}, w_ay, {SCALE_W{1'b0}}};
            r_xsgn <= 1'b0;
            r_ysgn <= w_ay[DIFF_W];
            r_step <= '0;
            r_dig  <= '0;
            r_ynz  <= 1'b0;
            r_cx   <= 1'b0;
            r_cy   <= 1'b0;
            if (i_ord == '0) begin
                r_z <= w_neg ? ANG_180 : '0;
            end else if (i_absc == '0) begin
                r_z <= i_ord[DIFF_W-1] ? -ANG_90 : ANG_90;
            end else if (w_neg) begin
                r_z <= i_ord[DIFF_W-1] ? -ANG_180 : ANG_180;
            end else begin
                r_z <= '0;
            end
        end else if (r_run) begin
            r_vx <= {w_nx, r_vx[VEC_W-1:DIGIT_W]};
            r_vy <= {w_ny, r_vy[VEC_W-1:DIGIT_W]};
            r_cx <= w_cx;
            r_cy <= w_cy;
            if (w_last_dig) begin
                r_dig  <= '0;
                r_ynz  <= 1'b0;
                r_xsgn <= w_nx[DIGIT_W-1];
                r_ysgn <= w_ny[DIGIT_W-1];
                r_z    <= r_ysgn ? r_z - w_atan : r_z + w_atan;
                r_step <= r_step + 1'b1;
            end else begin
                r_dig <= r_dig + 1'b1;
                r_ynz <= r_ynz | (|w_ny);
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;

endmodule

### rtl/compass_heading_hard_iron_cal_core.sv
`timescale 1ns / 1ps

// compass heading with hard-iron calibration
// i_in carries one magnetometer readout per beat: status byte and big-endian
// y, x, z byte pairs. o_out returns one result beat per readout: accepted flag,
// heading 1..360 (0 when rejected) and the assembled axes (0 when rejected).
// i_cfg writes calibrate_enable; writing 1 restarts x/y extreme tracking.
// Config beats are always taken and must only come while the block is idle.
// a readout with the busy status bit set goes straight to the output register.
// a normal readout runs extreme update, centering, load, then the bit-serial
// cordic: each step streams the 48-bit vector through 4-bit digits, up to
// CORDIC_STEPS steps (fewer once the residual ordinate is zero, none for
// axis-aligned vectors).
// one readout is in flight at a time; i_in.ready is high only in the idle state,
// and a new readout can enter while the previous result still waits in the
// output register. a stalled o_out holds the result and the next readout waits
// before its write into the output register.
// synchronous active-low reset clears the control state, disables calibration
// and sets the extremes to their reset values.
module compass_heading_hard_iron_cal_core import chhic_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    chhic_in_if.sink     i_in,
    chhic_out_if.source  o_out,
    chhic_cfg_if.sink    i_cfg
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CAL  = 6'b000010,
        S_CTR  = 6'b000100,
        S_LOAD = 6'b001000,
        S_ANG  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // captured readout
    logic                     r_item_ok;
    logic signed [AXIS_W-1:0] r_x, r_y, r_z;

    // output register
    logic                     r_o_valid;
    logic                     r_o_accepted;
    logic [HEAD_W-1:0]        r_o_heading;
    logic signed [AXIS_W-1:0] r_o_x, r_o_y, r_o_z;

    logic                     w_in_beat, w_out_free, w_out_load, w_done, w_round;
    t_cal_ctl                 w_cal_ctl;
    logic signed [DIFF_W-1:0] w_dx, w_dy;
    logic signed [ANG_W-1:0]  w_angle;
    logic signed [ANG_W-FRAC_W-1:0] w_deg_q;
    logic signed [DEG_W-1:0]  w_deg_t, w_deg_w;
    logic [HEAD_W-1:0]        w_heading;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_beat   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_o_valid || o_out.ready;
    assign w_out_load  = (r_state == S_OUT) && w_out_free;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_state = i_in.status_byte[BUSY_BIT] ? S_OUT : S_CAL;
                end
            end
            S_CAL:  n_state = S_CTR;
            S_CTR:  n_state = S_LOAD;
            S_LOAD: n_state = S_ANG;
            S_ANG: begin
                if (w_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_item_ok <= !i_in.status_byte[BUSY_BIT];
            r_x       <= {i_in.x_high_byte, i_in.x_low_byte};
            r_y       <= {i_in.y_high_byte, i_in.y_low_byte};
            r_z       <= {i_in.z_high_byte, i_in.z_low_byte};
        end
    end

    // extremes and centering
    assign w_cal_ctl.upd = (r_state == S_CAL) && r_item_ok;
    assign w_cal_ctl.ctr = (r_state == S_CTR);

    chhic_cal u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (i_cfg.valid && i_cfg.ready),
        .i_cfg_en (i_cfg.calibrate_enable),
        .i_ctl    (w_cal_ctl),
        .i_x      (r_x),
        .i_y      (r_y),
        .o_dx     (w_dx),
        .o_dy     (w_dy)
    );

    // atan2(dx, dy) in degrees
    chhic_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_ord   (w_dx),
        .i_absc  (w_dy),
        .o_done  (w_done),
        .o_angle (w_angle)
    );

    // truncate toward zero, wrap to 0..359, then 360 minus that
    assign w_deg_q   = w_angle[ANG_W-1:FRAC_W];
    assign w_round   = w_angle[ANG_W-1] && (|w_angle[FRAC_W-1:0]);
    assign w_deg_t   = DEG_W'(w_deg_q) + {{(DEG_W-1){1'b0}}, w_round};
    always_comb begin
        w_deg_w = w_deg_t;
        if (w_deg_t[DEG_W-1]) begin
            w_deg_w = w_deg_t + DEG_360;
        end else if (w_deg_t >= DEG_360) begin
            w_deg_w = w_deg_t - DEG_360;
        end
    end
    assign w_heading = HEAD_W'(DEG_360 - w_deg_w);

    // output register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_accepted <= r_item_ok;
            r_o_heading  <= r_item_ok ? w_heading : '0;
            r_o_x        <= r_item_ok ? r_x : '0;
            r_o_y        <= r_item_ok ? r_y : '0;
            r_o_z        <= r_item_ok ? r_z : '0;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.accepted        = r_o_accepted;
    assign o_out.heading_degrees = r_o_heading;
    assign o_out.x_value         = r_o_x;
    assign o_out.y_value         = r_o_y;
    assign o_out.z_value         = r_o_z;

    // cordic finishes only while the sequencer waits for it
    a_done_in_ang: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_ANG)
        else $error("cordic done outside angle wait");

    // busy readouts skip the datapath, good ones start with the extreme update
    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state == S_OUT) != (r_state == S_CAL))
        else $error("bad state after input beat");

    // accepted results carry a heading of 1..360, rejected ones carry zero
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.accepted ?
            (o_out.heading_degrees != '0 && o_out.heading_degrees <= HEAD_W'(360)) :
            (o_out.heading_degrees == '0)))
        else $error("heading out of range");

endmodule
